// ===== rtl/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// Substring search package
// Shared constants for the Horspool substring search block.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

    localparam int NEEDLE_MAX_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int ALPHABET        = 256;
    localparam int RESULT_BITS     = 32;

    localparam logic REQ_NEEDLE   = 1'b0;
    localparam logic REQ_HAYSTACK = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/hss_cell.sv =====
// ----------------------------------------------------------------------------
// Window compare cell
// Holds one needle byte and one window byte; shifts the window byte to the
// next cell and reports whether its active position matches.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_cell
    import hss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_win_byte,
    input  wire logic       i_ndl_we,
    input  wire logic [7:0] i_ndl_byte,
    input  wire logic [7:0] i_cmp_byte,
    input  wire logic       i_active,
    output logic      [7:0] o_win_byte,
    output logic            o_ok
);

    logic [7:0] r_win;
    logic [7:0] r_ndl;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= i_win_byte;
        end
        if (i_ndl_we) begin
            r_ndl <= i_ndl_byte;
        end
    end

    assign o_win_byte = r_win;
    assign o_ok = !i_active || (i_cmp_byte == r_ndl);

endmodule

`default_nettype wire

// ===== rtl/horspool_substring_search.sv =====
// ----------------------------------------------------------------------------
// Horspool substring search
// A result word is registered in the cycle after the deciding haystack byte.
// Throughput: one byte per cycle, except that a haystack byte whose alignment
// check fails stalls the input while its shift is read.
// The input also stalls while a result word waits on a stalled output.
// Reset clears needle length, table valid bits and search state.
// ----------------------------------------------------------------------------
`default_nettype none

module horspool_substring_search
    import hss_pkg::*;
#(
    parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic                   i_req_type,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_found,
    output logic [RESULT_BITS-1:0]      o_match_offset
);

    localparam int LW = $clog2(NEEDLE_MAX + 1);
    localparam int IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam logic [OFFSET_BITS-1:0] OMAX = '1;

    logic                   r_load_active;
    logic [LW-1:0]          r_load_count;
    logic [LW-1:0]          r_nlen;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_chk;
    logic                   r_done;
    logic [IW-1:0]          r_occ_idx [ALPHABET];
    logic [ALPHABET-1:0]    r_occ_vld;
    logic [7:0]             r_prev;
    logic                   r_pend;
    logic [IW-1:0]          r_occ_rd;
    logic                   r_occ_hit;

    logic [7:0] w_win [NEEDLE_MAX+1];
    logic [NEEDLE_MAX-1:0] w_ok;
    logic w_acc, w_hay, w_ndl_in, w_shift;

    assign o_stall  = (o_valid && i_stall) || r_pend;
    assign w_acc    = i_valid && !o_stall;
    assign w_hay    = w_acc && (i_req_type == REQ_HAYSTACK);
    assign w_ndl_in = w_acc && (i_req_type == REQ_NEEDLE);
    assign w_shift  = w_hay;
    assign w_win[NEEDLE_MAX] = i_data_byte;

    logic           w_start;
    logic [LW-1:0]  w_lc;
    assign w_start = w_ndl_in && !r_load_active;
    assign w_lc    = w_start ? '0 : r_load_count;

    // Cell k holds window position NEEDLE_MAX-1-k from the newest byte side;
    // the newest byte enters at the top cell.
    genvar g;
    generate
        for (g = 0; g < NEEDLE_MAX; g++) begin : g_cell
            logic       w_we;
            logic       w_act;
            logic [7:0] w_cmp;
            logic [LW:0] w_j;
            // Cell g compares the needle byte at index g; its window byte is
            // the one at distance nlen-1-g back from the incoming byte.
            assign w_we = w_ndl_in && (w_lc == LW'(g));
            assign w_act = (LW'(g) < r_nlen);
            assign w_j = (LW+1)'(NEEDLE_MAX) - (LW+1)'(r_nlen) + (LW+1)'(g) + 1'b1;
            assign w_cmp = (w_j >= (LW+1)'(NEEDLE_MAX)) ? i_data_byte
                         : w_win[w_j[LW-1:0]];
            hss_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (w_shift),
                .i_win_byte (w_win[g+1]),
                .i_ndl_we   (w_we),
                .i_ndl_byte (i_data_byte),
                .i_cmp_byte (w_cmp),
                .i_active   (w_act),
                .o_win_byte (w_win[g]),
                .o_ok       (w_ok[g])
            );
        end
    endgenerate

    logic                   w_check, w_match;
    logic [OFFSET_BITS:0]   w_end;
    logic [OFFSET_BITS:0]   w_shamt;
    logic [OFFSET_BITS:0]   w_nchk;
    logic [LW-1:0]          w_li;

    always_comb begin
        w_end   = {1'b0, r_chk} + (OFFSET_BITS+1)'(r_nlen) - 1'b1;
        w_check = !r_done && (r_nlen != '0) && (r_pos != OMAX)
               && !w_end[OFFSET_BITS] && (w_end[OFFSET_BITS-1:0] == r_pos);
        w_match = &w_ok;
        w_li    = r_nlen - 1'b1;
        w_shamt = (OFFSET_BITS+1)'(r_nlen);
        if (r_occ_hit && (LW'(r_occ_rd) < w_li)) begin
            w_shamt = (OFFSET_BITS+1)'(w_li - LW'(r_occ_rd));
        end
        w_nchk = {1'b0, r_chk} + w_shamt;
    end

    always_ff @(posedge i_clk) begin
        if (w_ndl_in && (w_lc < LW'(NEEDLE_MAX)) && (w_lc != '0)) begin
            r_occ_idx[r_prev] <= IW'(w_lc - 1'b1);
        end
        if (w_hay) begin
            r_occ_rd  <= r_occ_idx[i_data_byte];
            r_occ_hit <= r_occ_vld[i_data_byte];
        end
        if (w_ndl_in && (w_lc < LW'(NEEDLE_MAX))) begin
            r_prev <= i_data_byte;
        end
        if (w_acc && (w_hay ? (w_check && w_match) || (i_last_byte && !r_done)
                            : 1'b0)) begin
            o_found        <= w_check && w_match;
            o_match_offset <= (w_check && w_match) ? RESULT_BITS'(r_chk) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_active <= 1'b0;
            r_load_count  <= '0;
            r_nlen        <= '0;
            r_pos         <= '0;
            r_chk         <= '0;
            r_done        <= 1'b0;
            r_occ_vld     <= '0;
            r_pend        <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            r_pend <= w_hay && w_check && !w_match && !i_last_byte;
            if (r_pend) begin
                r_chk <= w_nchk[OFFSET_BITS] ? OMAX : w_nchk[OFFSET_BITS-1:0];
            end
            if (w_ndl_in) begin
                if (w_start) begin
                    r_nlen <= '0;
                    r_pos  <= '0;
                    r_chk  <= '0;
                    r_done <= 1'b0;
                end
                r_occ_vld <= w_start ? '0 : r_occ_vld;
                if ((w_lc < LW'(NEEDLE_MAX)) && (w_lc != '0)) begin
                    r_occ_vld[r_prev] <= 1'b1;
                end
                r_load_count  <= (w_lc < LW'(NEEDLE_MAX)) ? w_lc + 1'b1 : w_lc;
                r_load_active <= !i_last_byte;
                if (i_last_byte) begin
                    r_nlen <= (w_lc < LW'(NEEDLE_MAX)) ? w_lc + 1'b1 : w_lc;
                end
            end
            if (w_hay) begin
                if (w_check && w_match) begin
                    r_done  <= 1'b1;
                    o_valid <= 1'b1;
                end
                r_pos <= (r_pos == OMAX) ? OMAX : r_pos + 1'b1;
                if (i_last_byte) begin
                    if (!r_done) begin
                        o_valid <= 1'b1;
                    end
                    r_pos  <= '0;
                    r_chk  <= '0;
                    r_done <= 1'b0;
                end
            end
        end
    end

    a_found_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_match_offset == '0)
        else $error("not-found word carries an offset");
    a_done_no_nlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_nlen != '0)
        else $error("match reported without a needle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= LW'(NEEDLE_MAX))
        else $error("needle load count overflow");

endmodule

`default_nettype wire
